// ----- rtl/pkit_pkg.sv -----
// ----------------------------------------------------------------------------
// pkit_pkg: shared types and constants for the plane key intern table
// status codes, key layout and hash multipliers
// ----------------------------------------------------------------------------
`default_nettype none
package pkit_pkg;
   // canonical key terms are one bit wider than the input fields, since
   // negating the most negative input value needs the extra bit
   localparam int COEF_W = 10;
   localparam int OFFS_W = 14;
   localparam int KEY_W  = 3 * COEF_W + OFFS_W;   // 44 bits, canonical key

   localparam logic [1:0] STATUS_FOUND    = 2'd0;
   localparam logic [1:0] STATUS_INSERTED = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_ZERO     = 2'd3;

   localparam logic [31:0] HASH_MUL_X = 32'd73856093;
   localparam logic [31:0] HASH_MUL_Y = 32'd19349663;
   localparam logic [31:0] HASH_MUL_Z = 32'd83492791;
   localparam logic [31:0] HASH_MUL_D = 32'd2654435761;

   // payload of one result transaction
   typedef struct packed {
      logic [10:0] entry_id;
      logic [1:0]  status;
   } result_type;
endpackage
`default_nettype wire

// ----- rtl/pkit_ram.sv -----
// ----------------------------------------------------------------------------
// pkit_ram: generic single-port ram
// one write or one read per cycle, read data registered
// ----------------------------------------------------------------------------
`default_nettype none
module pkit_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// ----- rtl/plane_key_intern_table_unit.sv -----
// ----------------------------------------------------------------------------
// plane_key_intern_table_unit: canonical plane key interning
// reduces a plane by the normal gcd, hashes it, finds or inserts it by linear probing
// ----------------------------------------------------------------------------
// One transaction in, one result out. Each item is handled alone: a subtractive
// gcd over the normal magnitudes, one subtraction a cycle, run for each of the
// two pairs (for large coprime normals the gcd dominates), a restoring divider
// for the four terms, a sign fix, four hash multiplies (one per cycle), then a
// probe walk through the slot ram and key ram, with read, check and compare
// states for each occupied slot and read and check for the final empty one.
// An all-zero normal skips everything after the gcd. After reset a clearing pass
// over all 2^HASH_BITS slots empties them; no item is accepted until it ends.
// A finished result is held until the output register is free, and the next
// item is taken once the result has moved into the output register.
`default_nettype none
module plane_key_intern_table_unit
   import pkit_pkg::*;
#(
   parameter int HASH_BITS   = 12,
   parameter int MAX_ENTRIES = 2048
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // normal_x[8:0], normal_y[17:9], normal_z[26:18], offset[39:27]
   input  wire logic [39:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // entry_id[10:0], status[12:11], zero fill
   output logic      [15:0] rsp_tdata
);
   localparam int SLOTS  = 1 << HASH_BITS;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int ID_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int SLOT_W = ID_W + 1;   // valid bit plus id

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_GCD   = 4'd2;
   localparam logic [3:0] ST_DIV   = 4'd3;
   localparam logic [3:0] ST_SIGN  = 4'd4;
   localparam logic [3:0] ST_HASH  = 4'd5;
   localparam logic [3:0] ST_RDS   = 4'd6;
   localparam logic [3:0] ST_CHK   = 4'd7;
   localparam logic [3:0] ST_CMP   = 4'd8;
   localparam logic [3:0] ST_OUT   = 4'd9;

   logic [3:0]         state_ff, state_in;
   logic [HASH_BITS:0] clr_ff, clr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               out_valid_ff, out_valid_in;
   result_type         out_ff, out_in;
   result_type         res_ff, res_in;

   logic signed [OFFS_W-1:0] k_ff [4];
   logic signed [OFFS_W-1:0] k_in [4];
   logic [1:0]  gstep_ff, gstep_in;
   logic [8:0]  g_ff, g_in;
   logic [1:0]  di_ff, di_in;
   logic [3:0]  dbit_ff, dbit_in;
   logic [12:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [31:0] h_ff, h_in;
   logic [HASH_BITS-1:0] slot_ff, slot_in;
   logic [HASH_BITS:0]   probes_ff, probes_in;
   logic [ID_W-1:0]      cand_ff, cand_in;

   // ram ports
   logic              s_we, k_we;
   logic [HASH_BITS-1:0] s_addr;
   logic [SLOT_W-1:0] s_wd, s_rd;
   logic [ID_W-1:0]   k_addr;
   logic [KEY_W-1:0]  k_wd, k_rd, key_now;

   pkit_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_slot (
      .clock(clock), .wr_en(s_we), .addr(s_addr), .wr_data(s_wd), .rd_data(s_rd));
   pkit_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_key (
      .clock(clock), .wr_en(k_we), .addr(k_addr), .wr_data(k_wd), .rd_data(k_rd));

   assign key_now = {k_ff[3], k_ff[2][COEF_W-1:0], k_ff[1][COEF_W-1:0],
                     k_ff[0][COEF_W-1:0]};

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff.status, out_ff.entry_id};

   // helpers for the datapath
   logic [8:0]  mag_x, mag_y, mag_z;
   logic [12:0] dmag, rem_sh;
   logic [31:0] prod;
   logic        neg_flip;
   logic [ID_W-1:0] cnt_id;

   always_comb begin
      mag_x = req_tdata[8]  ? 9'(-req_tdata[8:0])   : req_tdata[8:0];
      mag_y = req_tdata[17] ? 9'(-req_tdata[17:9])  : req_tdata[17:9];
      mag_z = req_tdata[26] ? 9'(-req_tdata[26:18]) : req_tdata[26:18];
      dmag  = k_ff[di_ff][OFFS_W-1] ? 13'(-k_ff[di_ff]) : 13'(k_ff[di_ff]);
      rem_sh = {rem_ff[11:0], dmag[dbit_ff]};
      prod = 32'($signed(k_ff[di_ff])) * ((di_ff == 2'd0) ? HASH_MUL_X :
             (di_ff == 2'd1) ? HASH_MUL_Y : (di_ff == 2'd2) ? HASH_MUL_Z : HASH_MUL_D);
      neg_flip = k_ff[0] < 0 || (k_ff[0] == 0 && (k_ff[1] < 0 ||
                 (k_ff[1] == 0 && k_ff[2] < 0)));
      cnt_id = ID_W'(count_ff);
   end

   // control and datapath sequencer
   always_comb begin
      state_in = state_ff; clr_in = clr_ff; count_in = count_ff;
      out_valid_in = out_valid_ff; out_in = out_ff; res_in = res_ff;
      for (int i = 0; i < 4; i++) k_in[i] = k_ff[i];
      gstep_in = gstep_ff; g_in = g_ff;
      di_in = di_ff; dbit_in = dbit_ff; rem_in = rem_ff; quo_in = quo_ff;
      h_in = h_ff; slot_in = slot_ff; probes_in = probes_ff; cand_in = cand_ff;
      s_we = 1'b0; s_addr = slot_ff; s_wd = '0;
      k_we = 1'b0; k_addr = cand_ff; k_wd = key_now;

      if (out_valid_ff && rsp_tready) out_valid_in = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            s_we = 1'b1; s_addr = clr_ff[HASH_BITS-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (HASH_BITS+1)'(SLOTS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               k_in[0] = OFFS_W'($signed(req_tdata[8:0]));
               k_in[1] = OFFS_W'($signed(req_tdata[17:9]));
               k_in[2] = OFFS_W'($signed(req_tdata[26:18]));
               k_in[3] = OFFS_W'($signed(req_tdata[39:27]));
               // pairwise gcd: x with y first, then the result with z
               g_in = mag_x; gstep_in = 2'd0;
               // stash y and z magnitudes
               quo_in = {4'd0, mag_y}; rem_in = {4'd0, mag_z};
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            // euclid by subtraction on 9-bit values held in g_ff and quo_ff
            // step 0: gcd(g, quo) ; step 1: gcd(g, rem)
            if (quo_ff[8:0] == 9'd0) begin
               if (gstep_ff == 2'd0) begin
                  quo_in = rem_ff; gstep_in = 2'd1;
               end else if (g_ff == 9'd0) begin
                  res_in = '{entry_id: 11'd0, status: STATUS_ZERO};
                  state_in = ST_OUT;
               end else begin
                  di_in = '0; dbit_in = 4'd12; rem_in = '0; quo_in = '0;
                  state_in = ST_DIV;
               end
            end else if (g_ff >= quo_ff[8:0]) begin
               g_in = g_ff - quo_ff[8:0];
               if (g_ff - quo_ff[8:0] < quo_ff[8:0]) begin
                  g_in = quo_ff[8:0]; quo_in = {4'd0, g_ff - quo_ff[8:0]};
               end
            end else begin
               g_in = quo_ff[8:0]; quo_in = {4'd0, g_ff};
            end
         end
         ST_DIV: begin
            // restoring division of |k[di]| by g, one bit a cycle
            if ({1'b0, rem_sh} >= {5'd0, g_ff}) begin
               rem_in = rem_sh - {4'd0, g_ff};
               quo_in = {quo_ff[11:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[11:0], 1'b0};
            end
            dbit_in = dbit_ff - 1'b1;
            if (dbit_ff == 4'd0) begin
               k_in[di_ff] = k_ff[di_ff][OFFS_W-1] ? -$signed({1'b0, quo_in}) :
                             $signed({1'b0, quo_in});
               rem_in = '0; quo_in = '0; dbit_in = 4'd12;
               di_in = di_ff + 1'b1;
               if (di_ff == 2'd3) state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            if (neg_flip) for (int i = 0; i < 4; i++) k_in[i] = -k_ff[i];
            h_in = '0; di_in = '0;
            state_in = ST_HASH;
         end
         ST_HASH: begin
            h_in = h_ff ^ prod;
            di_in = di_ff + 1'b1;
            if (di_ff == 2'd3) begin
               slot_in = h_in[HASH_BITS-1:0]; probes_in = '0;
               state_in = ST_RDS;
            end
         end
         ST_RDS: begin
            s_addr = slot_ff;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (!s_rd[SLOT_W-1]) begin
               if (count_ff >= CNT_W'(MAX_ENTRIES)) begin
                  res_in = '{entry_id: 11'd0, status: STATUS_FULL};
               end else begin
                  s_we = 1'b1; s_addr = slot_ff; s_wd = {1'b1, cnt_id};
                  k_we = 1'b1; k_addr = cnt_id;
                  res_in = '{entry_id: 11'(count_ff), status: STATUS_INSERTED};
                  count_in = count_ff + 1'b1;
               end
               state_in = ST_OUT;
            end else begin
               cand_in = s_rd[ID_W-1:0]; k_addr = s_rd[ID_W-1:0];
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (k_rd == key_now) begin
               res_in = '{entry_id: 11'(cand_ff), status: STATUS_FOUND};
               state_in = ST_OUT;
            end else if (probes_ff == (HASH_BITS+1)'(SLOTS - 1)) begin
               res_in = '{entry_id: 11'd0, status: STATUS_FULL};
               state_in = ST_OUT;
            end else begin
               probes_in = probes_ff + 1'b1;
               slot_in = slot_ff + 1'b1;
               state_in = ST_RDS;
            end
         end
         ST_OUT: begin
            // move the result into the output register once it is free
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_in = res_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; clr_ff <= '0; count_ff <= '0; out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; count_ff <= count_in;
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
      res_ff <= res_in;
      for (int i = 0; i < 4; i++) k_ff[i] <= k_in[i];
      gstep_ff <= gstep_in;
      g_ff <= g_in; di_ff <= di_in; dbit_ff <= dbit_in; rem_ff <= rem_in;
      quo_ff <= quo_in; h_ff <= h_in; slot_ff <= slot_in; probes_ff <= probes_in;
      cand_ff <= cand_in;
   end
endmodule
`default_nettype wire

// ----- rtl/pkit_checker.sv -----
// ----------------------------------------------------------------------------
// pkit_checker: port-level checks for the intern table
// handshake and result code sanity over time
// ----------------------------------------------------------------------------
`default_nettype none
module pkit_checker
   import pkit_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);
   // result held while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   // full and zero normal carry id zero
   a_zero_id: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[12:11] == STATUS_FULL || rsp_tdata[12:11] == STATUS_ZERO)
      |-> rsp_tdata[10:0] == 11'd0)
      else $error("nonzero id with full or zero status");
   // one item at a time: no accept right after an accept
   a_seq: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transaction taken while busy");
   // a presented result is fully defined
   a_known: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !$isunknown(rsp_tdata))
      else $error("result data unknown");
endmodule

bind plane_key_intern_table_unit pkit_checker u_pkit_checker (.*);
`default_nettype wire

// ----- tb/sv/plane_key_intern_table_unit_test.sv -----
// ----------------------------------------------------------------------------
// plane_key_intern_table_unit_test: self-checking bench for the intern table
// drives plane transactions with random idling on both sides, predicts the
// canonical key, hash and probe walk in a local model, and compares every
// result transaction in order; ends with a stretch of transactions sent
// without any idling
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module plane_key_intern_table_unit_test
   import pkit_pkg::*;
();

   localparam int HASH_BITS   = 12;
   localparam int MAX_ENTRIES = 2048;
   localparam int SLOT_COUNT  = 1 << HASH_BITS;
   localparam int CYCLE_LIMIT = 20000000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // normal_x[8:0], normal_y[17:9], normal_z[26:18], offset[39:27]
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // entry_id[10:0], status[12:11], zero fill
   logic [15:0] rsp_tdata;

   // local copy of the table
   bit          slot_used [SLOT_COUNT];
   int          slot_entry [SLOT_COUNT];
   int          stored_key [MAX_ENTRIES][4];
   int          stored_count;

   result_type  pending_results [$];
   logic [39:0] sent_planes [$];
   int          mismatches;
   int          status_seen [4];
   int          cycle_count;
   int          ready_stall;
   bit          quiet;

   plane_key_intern_table_unit #(
      .HASH_BITS   (HASH_BITS),
      .MAX_ENTRIES (MAX_ENTRIES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // euclid on magnitudes
   function automatic int unsigned gcd_of(int unsigned p, int unsigned q);
      int unsigned t;
      while (q != 0) begin
         t = p % q;
         p = q;
         q = t;
      end
      return p;
   endfunction

   function automatic int unsigned magnitude(int v);
      return (v < 0) ? -v : v;
   endfunction

   // canonical reduction, hash and probe walk for one plane
   task automatic intern_plane(input logic [39:0] plane, output result_type res);
      int          k [4];
      int unsigned g;
      int unsigned h;
      bit          same;
      k[0] = int'($signed(plane[8:0]));
      k[1] = int'($signed(plane[17:9]));
      k[2] = int'($signed(plane[26:18]));
      k[3] = int'($signed(plane[39:27]));
      res.entry_id = '0;
      res.status   = STATUS_FULL;
      g = gcd_of(gcd_of(magnitude(k[0]), magnitude(k[1])), magnitude(k[2]));
      if (g == 0) begin
         res.status = STATUS_ZERO;
         return;
      end
      for (int i = 0; i < 4; i++) k[i] = k[i] / int'(g);
      if (k[0] < 0 || (k[0] == 0 && (k[1] < 0 || (k[1] == 0 && k[2] < 0))))
         for (int i = 0; i < 4; i++) k[i] = -k[i];
      h = (unsigned'(k[0]) * HASH_MUL_X) ^ (unsigned'(k[1]) * HASH_MUL_Y) ^
          (unsigned'(k[2]) * HASH_MUL_Z) ^ (unsigned'(k[3]) * HASH_MUL_D);
      h = h & (SLOT_COUNT - 1);
      for (int n = 0; n < SLOT_COUNT; n++) begin
         if (!slot_used[h]) begin
            if (stored_count >= MAX_ENTRIES) return;
            slot_used[h]  = 1'b1;
            slot_entry[h] = stored_count;
            for (int i = 0; i < 4; i++) stored_key[stored_count][i] = k[i];
            res.entry_id  = stored_count[10:0];
            res.status    = STATUS_INSERTED;
            stored_count++;
            return;
         end
         same = 1'b1;
         for (int i = 0; i < 4; i++)
            if (stored_key[slot_entry[h]][i] != k[i]) same = 1'b0;
         if (slot_entry[h] < stored_count && same) begin
            res.entry_id = slot_entry[h][10:0];
            res.status   = STATUS_FOUND;
            return;
         end
         h = (h + 1) & (SLOT_COUNT - 1);
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      mismatches++;
   endtask

   // send one plane transaction, then maybe idle
   task automatic send_plane(input logic [39:0] plane);
      result_type res;
      req_tvalid <= 1'b1;
      req_tdata  <= plane;
      do @(posedge clock); while (!req_tready);
      intern_plane(plane, res);
      pending_results.push_back(res);
      sent_planes.push_back(plane);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   function automatic logic [39:0] pack_plane(int x, int y, int z, int d);
      return {d[12:0], z[8:0], y[8:0], x[8:0]};
   endfunction

   // well-formed plane: offset divisible by gcd most of the time
   function automatic logic [39:0] random_plane();
      int x, y, z, d;
      int unsigned g;
      if ($urandom_range(0, 9) < 7) begin
         x = $signed($urandom_range(0, 16)) - 8;
         y = $signed($urandom_range(0, 16)) - 8;
         z = $signed($urandom_range(0, 16)) - 8;
      end else begin
         x = $signed($urandom_range(0, 256)) - 128;
         y = $signed($urandom_range(0, 256)) - 128;
         z = $signed($urandom_range(0, 256)) - 128;
      end
      g = gcd_of(gcd_of(magnitude(x), magnitude(y)), magnitude(z));
      d = $signed($urandom_range(0, 6144)) - 3072;
      if (g > 1 && $urandom_range(0, 3) != 0) d = (d / int'(g)) * int'(g);
      return pack_plane(x, y, z, d);
   endfunction

   // earlier plane scaled and maybe negated: same canonical key
   function automatic logic [39:0] repeat_plane();
      logic [39:0] p;
      int x, y, z, d, m;
      p = sent_planes[$urandom_range(0, sent_planes.size() - 1)];
      x = $signed(p[8:0]);
      y = $signed(p[17:9]);
      z = $signed(p[26:18]);
      d = $signed(p[39:27]);
      m = $urandom_range(1, 3);
      if (magnitude(x * m) > 128 || magnitude(y * m) > 128 || magnitude(z * m) > 128 ||
          magnitude(d * m) > 3072) m = 1;
      if ($urandom_range(0, 1)) m = -m;
      return pack_plane(x * m, y * m, z * m, d * m);
   endfunction

   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic test_directed_planes();
      send_plane(pack_plane(0, 0, 0, 0));
      send_plane(pack_plane(0, 0, 0, -3072));
      send_plane(pack_plane(1, 0, 0, 0));
      send_plane(pack_plane(1, 0, 0, 0));
      send_plane(pack_plane(-2, 0, 0, -5));
      send_plane(pack_plane(2, 0, 0, 5));
      send_plane(pack_plane(0, -3, 6, 7));
      send_plane(pack_plane(0, 3, -6, -7));
      send_plane(pack_plane(0, 0, -5, 9));
      send_plane(pack_plane(128, 128, 128, 3072));
      send_plane(pack_plane(-128, -128, -128, -3072));
      send_plane(pack_plane(-128, 0, 0, 3071));
      send_plane(pack_plane(127, -127, 1, -1));
      // raw patterns outside the nominal ranges
      send_plane({13'h1000, 9'h100, 9'h100, 9'h100});
      send_plane({13'h0fff, 9'h0ff, 9'h0ff, 9'h0ff});
      send_plane({13'h1fff, 9'h1ff, 9'h000, 9'h000});
      send_plane({13'h0aaa, 9'h155, 9'h0aa, 9'h155});
      send_plane({13'h1555, 9'h0aa, 9'h155, 9'h0aa});
      send_plane(pack_plane(6, 9, 15, 10));
      send_plane(pack_plane(-6, -9, -15, -10));
   endtask

   task automatic test_random_planes(input int count);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: send_plane(repeat_plane());
            3:       send_plane({8'($urandom()), $urandom()});
            default: send_plane(random_plane());
         endcase
         // hold off once until the block has caught up
         if (i == count / 2) wait_until_drained();
      end
   endtask

   // closing stretch with no idling on either side
   task automatic test_back_to_back_tail();
      quiet = 1'b1;
      for (int i = 0; i < 12; i++) send_plane(random_plane());
      for (int i = 0; i < 12; i++) send_plane(repeat_plane());
      send_plane(pack_plane(0, 0, 0, 17));
   endtask

   // result checker
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            want = pending_results.pop_front();
            status_seen[want.status]++;
            if (rsp_tdata[12:11] != want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_tdata[12:11], want.status));
            if (rsp_tdata[10:0] != want.entry_id)
               report_mismatch($sformatf("entry_id %0d, expected %0d",
                                         rsp_tdata[10:0], want.entry_id));
         end
      end
   end

   // receiver back-pressure bursts
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_tready  <= !reset;
         ready_stall <= 0;
      end else if (ready_stall > 0) begin
         rsp_tready  <= 1'b0;
         ready_stall <= ready_stall - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_tready  <= 1'b0;
         ready_stall <= $urandom_range(0, 2);
      end else begin
         rsp_tready  <= 1'b1;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL plane_key_intern_table_unit");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      cycle_count  = 0;
      ready_stall  = 0;
      quiet        = 1'b0;
      mismatches   = 0;
      stored_count = 0;
      for (int i = 0; i < 4; i++) status_seen[i] = 0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_used[i]  = 1'b0;
         slot_entry[i] = 0;
      end
      for (int i = 0; i < MAX_ENTRIES; i++)
         for (int j = 0; j < 4; j++) stored_key[i][j] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_planes();
      test_random_planes(1105);
      test_back_to_back_tail();

      req_tvalid <= 1'b0;
      wait_until_drained();
      repeat (200) @(posedge clock);
      if (pending_results.size() != 0) report_mismatch("results never arrived");

      $display("covered %0d found, %0d inserted, %0d full, %0d zero-normal results",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      $display("table held %0d keys, %0d mismatches", stored_count, mismatches);
      if (mismatches == 0) begin
         $display("PASS plane_key_intern_table_unit");
      end else begin
         $display("FAIL plane_key_intern_table_unit");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/pkit_pkg.sv
rtl/pkit_ram.sv
rtl/plane_key_intern_table_unit.sv
rtl/pkit_checker.sv
tb/sv/plane_key_intern_table_unit_test.sv
